FILE: sv/dssp_pkg.sv
`default_nettype none

package dssp_pkg;

   localparam int unsigned ADC_W     = 10;
   localparam int unsigned LIMIT_W   = 7;
   localparam int unsigned PCT_W     = 7;
   localparam int unsigned DIGIT_W   = 2;
   localparam int unsigned SEG_W     = 8;
   localparam int unsigned GLYPH_W   = 4;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned NUM_DIGITS = 3;

   // scaled numerator |(x - lo) * 100| and its quotient
   localparam int unsigned NUM_W = 17;

   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   localparam logic [ADC_W-1:0]   RST_LOW_A  = 10'd190;
   localparam logic [ADC_W-1:0]   RST_HIGH_A = 10'd833;
   localparam logic [ADC_W-1:0]   RST_LOW_B  = 10'd87;
   localparam logic [ADC_W-1:0]   RST_HIGH_B = 10'd413;
   localparam logic [LIMIT_W-1:0] RST_LIMIT  = 7'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LOW_A          = 3'd0,
      REG_HIGH_A         = 3'd1,
      REG_LOW_B          = 3'd2,
      REG_HIGH_B         = 3'd3,
      REG_MISMATCH_LIMIT = 3'd4
   } csr_index_type;

   localparam logic [DIGIT_W-1:0] DIGIT_HUNDREDS = 2'd0;
   localparam logic [DIGIT_W-1:0] DIGIT_TENS     = 2'd1;
   localparam logic [DIGIT_W-1:0] DIGIT_ONES     = 2'd2;

   localparam logic [GLYPH_W-1:0] GLYPH_E = 4'd10;
   localparam logic [GLYPH_W-1:0] GLYPH_R = 4'd11;

   localparam logic [SEG_W-1:0] SEG_E = 8'h06;
   localparam logic [SEG_W-1:0] SEG_R = 8'h2F;

   // queued display job: both latest samples and the digit to show
   typedef struct packed {
      logic [ADC_W-1:0]   sample_a;
      logic [ADC_W-1:0]   sample_b;
      logic [DIGIT_W-1:0] digit;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [SEG_W-1:0] glyph_segments(input logic [GLYPH_W-1:0] g);
      logic [SEG_W-1:0] seg;
      case (g)
         4'd0:    seg = 8'h40;
         4'd1:    seg = 8'h79;
         4'd2:    seg = 8'h24;
         4'd3:    seg = 8'h30;
         4'd4:    seg = 8'h19;
         4'd5:    seg = 8'h12;
         4'd6:    seg = 8'h02;
         4'd7:    seg = 8'h78;
         4'd8:    seg = 8'h80;
         4'd9:    seg = 8'h18;
         4'd10:   seg = SEG_E;
         4'd11:   seg = SEG_R;
         default: seg = 8'h40;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

FILE: sv/dssp_if.sv
`default_nettype none

interface dssp_req_if;
   logic                       valid;
   logic                       ready;
   logic [dssp_pkg::ADC_W-1:0] adc_value;

   modport source (output valid, output adc_value, input ready);
   modport sink   (input valid, input adc_value, output ready);
endinterface

interface dssp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dssp_pkg::DIGIT_W-1:0] digit_select;
   logic [dssp_pkg::SEG_W-1:0]   segment_pattern;
   logic                         mismatch;

   modport source (output valid, output digit_select, output segment_pattern,
                   output mismatch, input ready);
   modport sink   (input valid, input digit_select, input segment_pattern,
                   input mismatch, output ready);
endinterface

`default_nettype wire

FILE: sv/dssp_front.sv
`default_nettype none

module dssp_front #(
   parameter int unsigned SAMPLES_PER_DIGIT = 10
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   dssp_req_if.sink                        req_ch,
   input  wire dssp_pkg::queue_status_type q_status,
   output logic                            q_push,
   output dssp_pkg::job_type               q_job
);
   import dssp_pkg::*;

   localparam int unsigned TICK_W = $clog2(SAMPLES_PER_DIGIT + 1);
   localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(SAMPLES_PER_DIGIT - 1);

   logic [ADC_W-1:0]   sample_a_ff, sample_a_in;
   logic [ADC_W-1:0]   sample_b_ff, sample_b_in;
   logic               next_ch_ff, next_ch_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic               accept;
   logic               tick_hit;

   assign req_ch.ready = !q_status.full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign tick_hit     = (tick_ff == TICK_LAST);

   always_comb begin
      sample_a_in = sample_a_ff;
      sample_b_in = sample_b_ff;
      next_ch_in  = next_ch_ff;
      tick_in     = tick_ff;
      digit_in    = digit_ff;
      q_push      = 1'b0;
      if (accept) begin
         if (!next_ch_ff) begin
            sample_a_in = req_ch.adc_value;
         end else begin
            sample_b_in = req_ch.adc_value;
         end
         next_ch_in = !next_ch_ff;
         if (tick_hit) begin
            tick_in  = '0;
            digit_in = (digit_ff == DIGIT_ONES) ? DIGIT_HUNDREDS : digit_ff + 2'd1;
            q_push   = 1'b1;
         end else begin
            tick_in = tick_ff + TICK_W'(1);
         end
      end
      q_job.sample_a = sample_a_in;
      q_job.sample_b = sample_b_in;
      q_job.digit    = digit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_a_ff <= '0;
         sample_b_ff <= '0;
         next_ch_ff  <= 1'b0;
         tick_ff     <= '0;
         digit_ff    <= DIGIT_HUNDREDS;
      end else begin
         sample_a_ff <= sample_a_in;
         sample_b_ff <= sample_b_in;
         next_ch_ff  <= next_ch_in;
         tick_ff     <= tick_in;
         digit_ff    <= digit_in;
      end
   end

`ifndef SYNTHESIS
   a_push_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      q_push |-> accept && tick_hit)
      else $error("job pushed without a display tick");

   a_tick_bounded: assert property (@(posedge clock) disable iff (reset)
      tick_ff <= TICK_LAST)
      else $error("tick counter past its wrap value");

   a_digit_advance: assert property (@(posedge clock) disable iff (reset)
      q_push |=> (digit_ff != $past(digit_ff)) && (digit_ff != 2'd3))
      else $error("digit index did not advance on a tick");
`endif

endmodule

`default_nettype wire

FILE: sv/dssp_queue.sv
`default_nettype none

module dssp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire dssp_pkg::job_type    push_job,
   input  wire logic                 pop,
   output dssp_pkg::job_type         pop_job,
   output dssp_pkg::queue_status_type status
);
   import dssp_pkg::*;

   localparam int unsigned DEPTH = 2;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   job_type            mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_job      = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("job pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("job popped from an empty queue");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count past depth");
`endif

endmodule

`default_nettype wire

FILE: sv/dssp_back.sv
`default_nettype none

module dssp_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [dssp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dssp_pkg::ADC_W-1:0]        csr_wdata,
   input  wire dssp_pkg::queue_status_type        q_status,
   input  wire dssp_pkg::job_type                 q_job,
   output logic                                   q_pop,
   dssp_rsp_if.source                             rsp_ch
);
   import dssp_pkg::*;

   localparam int unsigned STEP_W = $clog2(NUM_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LOAD  = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_CALC  = 6'b001000,
      ST_TENS  = 6'b010000,
      ST_GLYPH = 6'b100000
   } state_type;

   state_type          state_ff, state_in;

   logic [ADC_W-1:0]   low_a_ff, high_a_ff, low_b_ff, high_b_ff;
   logic [LIMIT_W-1:0] limit_ff;

   job_type            job_ff, job_in;
   logic               sel_ff, sel_in;
   logic [NUM_W-1:0]   quot_ff, quot_in;
   logic [ADC_W-1:0]   rem_ff, rem_in;
   logic [ADC_W-1:0]   divisor_ff, divisor_in;
   logic               zero_ff, zero_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [PCT_W-1:0]   pct_a_ff, pct_a_in;
   logic [PCT_W-1:0]   pct_b_ff, pct_b_in;
   logic [PCT_W-1:0]   avg_ff, avg_in;
   logic               err_ff, err_in;
   logic [GLYPH_W-1:0] tens_ff, tens_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_W-1:0] rsp_digit_ff, rsp_digit_in;
   logic [SEG_W-1:0]   rsp_seg_ff, rsp_seg_in;
   logic               rsp_mis_ff, rsp_mis_in;

   // operand setup for one percentage division
   logic [ADC_W-1:0]   x_sel, lo_sel, hi_sel;
   logic signed [10:0] delta, span;
   logic signed [17:0] num;
   logic [17:0]        num_abs;
   logic [10:0]        span_abs;
   // one restoring step
   logic [ADC_W:0]     rem_shift;
   logic               q_bit;
   logic [PCT_W-1:0]   pct_new;
   // digit math
   logic [PCT_W:0]     pct_sum;
   logic [PCT_W-1:0]   pct_diff;
   logic [14:0]        recip_prod;
   logic [PCT_W-1:0]   tens_x10;
   logic [PCT_W-1:0]   ones_full;
   logic [GLYPH_W-1:0] glyph;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      x_sel    = sel_ff ? job_ff.sample_b : job_ff.sample_a;
      lo_sel   = sel_ff ? low_b_ff  : low_a_ff;
      hi_sel   = sel_ff ? high_b_ff : high_a_ff;
      delta    = $signed({1'b0, x_sel}) - $signed({1'b0, lo_sel});
      span     = $signed({1'b0, hi_sel}) - $signed({1'b0, lo_sel});
      num      = 18'(delta) * 18'sd100;
      num_abs  = num[17] ? 18'(-num) : 18'(num);
      span_abs = span[10] ? 11'(-span) : 11'(span);

      rem_shift = {rem_ff, quot_ff[NUM_W-1]};
      q_bit     = (rem_shift >= {1'b0, divisor_ff});
      pct_new   = '0;

      pct_sum    = {1'b0, pct_a_ff} + {1'b0, pct_b_ff};
      pct_diff   = (pct_a_ff > pct_b_ff) ? pct_a_ff - pct_b_ff : pct_b_ff - pct_a_ff;
      // avg / 10 for avg below 1029
      recip_prod = 15'(avg_ff) * 15'd205;
      tens_x10   = 7'({tens_ff, 3'b000}) + 7'({tens_ff, 1'b0});
      ones_full  = avg_ff - tens_x10;

      if (err_ff) begin
         glyph = (job_ff.digit == DIGIT_HUNDREDS) ? GLYPH_E : GLYPH_R;
      end else begin
         case (job_ff.digit)
            DIGIT_HUNDREDS: glyph = (avg_ff == PCT_FULL) ? 4'd1 : 4'd0;
            DIGIT_TENS:     glyph = (tens_ff == 4'd10) ? 4'd0 : tens_ff;
            default:        glyph = ones_full[GLYPH_W-1:0];
         endcase
      end

      state_in     = state_ff;
      job_in       = job_ff;
      sel_in       = sel_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      zero_in      = zero_ff;
      step_in      = step_ff;
      pct_a_in     = pct_a_ff;
      pct_b_in     = pct_b_ff;
      avg_in       = avg_ff;
      err_in       = err_ff;
      tens_in      = tens_ff;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_digit_in = rsp_digit_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_mis_in   = rsp_mis_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               job_in   = q_job;
               sel_in   = 1'b0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // a quotient of the wrong sign, or zero span, saturates to zero
            zero_in    = (span == '0) || (num == '0) || (num[17] != span[10]);
            quot_in    = num_abs[NUM_W-1:0];
            divisor_in = span_abs[ADC_W-1:0];
            rem_in     = '0;
            step_in    = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = q_bit ? ADC_W'(rem_shift - {1'b0, divisor_ff})
                            : rem_shift[ADC_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], q_bit};
            step_in = step_ff + STEP_W'(1);
            if (zero_ff) begin
               pct_new = '0;
            end else if (quot_in > NUM_W'(PCT_FULL)) begin
               pct_new = PCT_FULL;
            end else begin
               pct_new = quot_in[PCT_W-1:0];
            end
            if (step_ff == STEP_LAST) begin
               if (!sel_ff) begin
                  pct_a_in = pct_new;
                  sel_in   = 1'b1;
                  state_in = ST_LOAD;
               end else begin
                  pct_b_in = pct_new;
                  state_in = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            avg_in   = pct_sum[PCT_W:1];
            err_in   = pct_diff > limit_ff;
            state_in = ST_TENS;
         end
         ST_TENS: begin
            tens_in  = recip_prod[14:11];
            state_in = ST_GLYPH;
         end
         ST_GLYPH: begin
            // hold until the output register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_digit_in = job_ff.digit;
               rsp_seg_in   = glyph_segments(glyph);
               rsp_mis_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_a_ff  <= RST_LOW_A;
         high_a_ff <= RST_HIGH_A;
         low_b_ff  <= RST_LOW_B;
         high_b_ff <= RST_HIGH_B;
         limit_ff  <= RST_LIMIT;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_LOW_A:          low_a_ff  <= csr_wdata;
            REG_HIGH_A:         high_a_ff <= csr_wdata;
            REG_LOW_B:          low_b_ff  <= csr_wdata;
            REG_HIGH_B:         high_b_ff <= csr_wdata;
            REG_MISMATCH_LIMIT: limit_ff  <= csr_wdata[LIMIT_W-1:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      sel_ff       <= sel_in;
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      zero_ff      <= zero_in;
      step_ff      <= step_in;
      pct_a_ff     <= pct_a_in;
      pct_b_ff     <= pct_b_in;
      avg_ff       <= avg_in;
      err_ff       <= err_in;
      tens_ff      <= tens_in;
      rsp_digit_ff <= rsp_digit_in;
      rsp_seg_ff   <= rsp_seg_in;
      rsp_mis_ff   <= rsp_mis_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.digit_select    = rsp_digit_ff;
   assign rsp_ch.segment_pattern = rsp_seg_ff;
   assign rsp_ch.mismatch        = rsp_mis_ff;

`ifndef SYNTHESIS
   a_error_glyphs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_mis_ff |->
         (rsp_seg_ff == SEG_E && rsp_digit_ff == DIGIT_HUNDREDS) ||
         (rsp_seg_ff == SEG_R && rsp_digit_ff != DIGIT_HUNDREDS))
      else $error("mismatch flagged without the error word");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_digit_ff != 2'd3)
      else $error("digit select out of range");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CALC |-> pct_a_ff <= PCT_FULL && pct_b_ff <= PCT_FULL)
      else $error("percentage above full scale");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE && !q_status.empty)
      else $error("job taken while busy");
`endif

endmodule

`default_nettype wire

FILE: sv/dual_sensor_percent_seven_seg.sv
// Two-sensor percentage monitor for a multiplexed three-digit seven-segment
// display. Conversion results arrive on req_ch alternating sensor A, sensor B
// (A first after reset). Every SAMPLES_PER_DIGIT-th transaction advances the
// digit (hundreds, tens, ones) and queues one display job; all other
// transactions produce nothing. Each job yields one rsp_ch transaction with the
// active-low segment byte of that digit of the average percentage, or of "Err"
// with mismatch set when the two sensors differ by more than the limit.
// The input side takes one transaction per cycle while the two-entry job queue
// has room. Each job runs two 17-step restoring divisions in one shared divider
// in the back end, which takes a new job only once the last one is in the
// output register; when it falls behind, the queue fills and the input stalls.
// Register writes on csr_* are to be made while no job is in flight.
`default_nettype none

module dual_sensor_percent_seven_seg #(
   parameter int unsigned SAMPLES_PER_DIGIT = 10
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   dssp_req_if.sink                            req_ch,
   dssp_rsp_if.source                          rsp_ch,
   input  wire logic                           csr_wr_en,
   input  wire logic [dssp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [dssp_pkg::ADC_W-1:0]     csr_wdata
);
   import dssp_pkg::*;

   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   job_type          push_job;
   job_type          pop_job;

   dssp_front #(
      .SAMPLES_PER_DIGIT (SAMPLES_PER_DIGIT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .q_status (q_status),
      .q_push   (q_push),
      .q_job    (push_job)
   );

   dssp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .status   (q_status)
   );

   dssp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_status  (q_status),
      .q_job     (pop_job),
      .q_pop     (q_pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import dssp_pkg::*;

   localparam int unsigned SAMPLES_PER_DIGIT = 10;
   localparam int unsigned DRAIN_CYCLES      = 100;
   localparam int unsigned HOLD_OFF_CYCLES   = 400;
   localparam int unsigned MAX_REPORTS       = 200;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic [SEG_W-1:0]   segments;
      logic               mismatch;
   } shown_digit_type;

   class digit_scoreboard;
      logic [ADC_W-1:0]   low_a, high_a, low_b, high_b;
      logic [LIMIT_W-1:0] limit;
      logic [ADC_W-1:0]   last_a, last_b;
      bit                 on_b;
      int unsigned        tick;
      logic [DIGIT_W-1:0] digit;
      logic [SEG_W-1:0]   glyph_segs [12];
      shown_digit_type    pending_digits [$];
      int unsigned        errors;

      function new();
         low_a  = RST_LOW_A;
         high_a = RST_HIGH_A;
         low_b  = RST_LOW_B;
         high_b = RST_HIGH_B;
         limit  = RST_LIMIT;
         last_a = '0;
         last_b = '0;
         on_b   = 1'b0;
         tick   = 0;
         digit  = DIGIT_HUNDREDS;
         errors = 0;
         glyph_segs = '{8'h40, 8'h79, 8'h24, 8'h30, 8'h19, 8'h12,
                        8'h02, 8'h78, 8'h80, 8'h18, 8'h06, 8'h2F};
      endfunction

      function void set_reg(csr_index_type idx, logic [ADC_W-1:0] value);
         case (idx)
            REG_LOW_A:          low_a  = value;
            REG_HIGH_A:         high_a = value;
            REG_LOW_B:          low_b  = value;
            REG_HIGH_B:         high_b = value;
            REG_MISMATCH_LIMIT: limit  = value[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      // signed map, truncated toward zero, then clipped to 0..100
      function int scale_to_percent(int x, int lo, int hi);
         int span;
         int q;
         span = hi - lo;
         if (span == 0) return 0;
         q = ((x - lo) * 100) / span;
         if (q < 0) return 0;
         if (q > 100) return 100;
         return q;
      endfunction

      function void note_sample(logic [ADC_W-1:0] value);
         int pa, pb, avg, diff, glyph;
         bit err;
         shown_digit_type shown;
         if (on_b) last_b = value;
         else last_a = value;
         on_b = !on_b;
         tick++;
         if (tick < SAMPLES_PER_DIGIT) return;
         tick  = 0;
         digit = (digit == DIGIT_ONES) ? DIGIT_HUNDREDS : digit + 2'd1;

         pa   = scale_to_percent(int'(last_a), int'(low_a), int'(high_a));
         pb   = scale_to_percent(int'(last_b), int'(low_b), int'(high_b));
         avg  = (pa + pb) / 2;
         diff = (pa > pb) ? pa - pb : pb - pa;
         err  = diff > int'(limit);

         if (err) glyph = (digit == DIGIT_HUNDREDS) ? int'(GLYPH_E) : int'(GLYPH_R);
         else if (digit == DIGIT_HUNDREDS) glyph = avg / 100;
         else if (digit == DIGIT_TENS) glyph = (avg / 10) % 10;
         else glyph = avg % 10;

         shown.digit    = digit;
         shown.segments = glyph_segs[glyph];
         shown.mismatch = err;
         pending_digits.push_back(shown);
      endfunction

      task report(string msg);
         if (errors < MAX_REPORTS) $display("MISMATCH %0t: %s", $time, msg);
         errors++;
      endtask

      task check_digit(shown_digit_type got);
         shown_digit_type want;
         if (pending_digits.size() == 0) begin
            report($sformatf("unexpected transaction digit=%0d seg=%02h mismatch=%0b",
                             got.digit, got.segments, got.mismatch));
            return;
         end
         want = pending_digits.pop_front();
         if (got.digit !== want.digit)
            report($sformatf("digit_select %0d, want %0d", got.digit, want.digit));
         if (got.segments !== want.segments)
            report($sformatf("segment_pattern %02h, want %02h (digit %0d)",
                             got.segments, want.segments, want.digit));
         if (got.mismatch !== want.mismatch)
            report($sformatf("mismatch %0b, want %0b", got.mismatch, want.mismatch));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADC_W-1:0]     csr_wdata;

   dssp_req_if req_ch ();
   dssp_rsp_if rsp_ch ();

   dual_sensor_percent_seven_seg #(
      .SAMPLES_PER_DIGIT (SAMPLES_PER_DIGIT)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   digit_scoreboard sb = new();

   int unsigned src_idle = 0;
   int unsigned snk_idle = 0;
   logic        hold_rsp;
   int unsigned offered  = 0;
   int          pair_pct = 50;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // input monitor: every accepted conversion goes to the predictor
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         sb.note_sample(req_ch.adc_value);
   end

   // display side: check, then decide ready for the next edge
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_digit('{rsp_ch.digit_select, rsp_ch.segment_pattern, rsp_ch.mismatch});
         rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= snk_idle);
      end
   end

   task automatic send_sample(input logic [ADC_W-1:0] value);
      while ($urandom_range(99) < src_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.adc_value <= value;
      offered++;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic set_register(input csr_index_type idx, input logic [ADC_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   task automatic write_registers(input logic [ADC_W-1:0] la, ha, lb, hb,
                                  input logic [LIMIT_W-1:0] lim);
      set_register(REG_LOW_A, la);
      set_register(REG_HIGH_A, ha);
      set_register(REG_LOW_B, lb);
      set_register(REG_HIGH_B, hb);
      set_register(REG_MISMATCH_LIMIT, {3'b000, lim});
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // mostly plausible pairs: B tracks A's percentage with some jitter
   function automatic logic [ADC_W-1:0] next_sample(input bit chan_b);
      int lo, hi, p, v;
      if ($urandom_range(99) < 12) return ADC_W'($urandom_range(1023));
      if (!chan_b) begin
         pair_pct = ($urandom_range(9) == 0) ? int'($urandom_range(140)) - 20
                                             : int'($urandom_range(100));
         lo = sb.low_a;
         hi = sb.high_a;
         p  = pair_pct;
      end else begin
         lo = sb.low_b;
         hi = sb.high_b;
         p  = pair_pct + int'($urandom_range(30)) - 15;
      end
      v = lo + (p * (hi - lo)) / 100 + int'($urandom_range(2)) - 1;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return ADC_W'(v);
   endfunction

   task automatic run_random(input int unsigned count, input int unsigned src_pct,
                             input int unsigned snk_pct);
      src_idle = src_pct;
      snk_idle = snk_pct;
      repeat (count) send_sample(next_sample(offered[0]));
      req_ch.valid <= 1'b0;
   endtask

   // all expected digits shown, then let the back end settle
   task automatic wait_drained();
      @(posedge clock);
      while (sb.pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   logic [ADC_W-1:0] directed_values [30] = '{
      10'd0,    10'd1023, 10'h155, 10'h2AA, 10'd1,   10'd512, 10'd1022, 10'd2,
      10'd833,  10'd413,
      10'd190,  10'd87,   10'd1023, 10'd0,  10'h200, 10'h100, 10'h3FF, 10'h001,
      10'd1023, 10'd0,
      10'h0AA,  10'h355,  10'd5,   10'd1020, 10'd700, 10'd300, 10'd0,  10'd1023,
      10'd511,  10'd250
   };

   initial begin
      int unsigned mode;
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.adc_value <= '0;
      hold_rsp         <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset ranges: full-scale, saturated mismatch, mid-scale
      foreach (directed_values[i]) send_sample(directed_values[i]);
      req_ch.valid <= 1'b0;
      wait_drained();

      run_random(200, 0, 0);
      run_random(200, 73, 0);
      run_random(200, 0, 73);
      run_random(200, 15, 15);
      wait_drained();

      // widest span, zero tolerance
      write_registers(10'd0, 10'd1023, 10'd0, 10'd1023, 7'd0);
      run_random(150, 0, 0);
      wait_drained();

      // inverted ranges, limit beyond 100 never flags
      write_registers(10'd1023, 10'd0, 10'd1000, 10'd24, 7'd127);
      run_random(150, 15, 15);
      wait_drained();

      // zero span on A pins it at zero percent
      write_registers(10'd512, 10'd512, 10'd0, 10'd1023, 7'd100);
      run_random(100, 0, 73);
      wait_drained();

      // long receiver hold-off: queue fills, input backs up
      write_registers(RST_LOW_A, RST_HIGH_A, RST_LOW_B, RST_HIGH_B, RST_LIMIT);
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      run_random(200, 0, 0);
      wait_drained();

      repeat (4) begin
         write_registers(ADC_W'($urandom_range(1023)), ADC_W'($urandom_range(1023)),
                         ADC_W'($urandom_range(1023)), ADC_W'($urandom_range(1023)),
                         LIMIT_W'($urandom_range(127)));
         mode = $urandom_range(3);
         case (mode)
            0: run_random(100, 0, 0);
            1: run_random(100, 73, 0);
            2: run_random(100, 0, 73);
            default: run_random(100, 15, 15);
         endcase
         wait_drained();
      end

      if (sb.errors == 0)
         $display("dual_sensor_percent_seven_seg test passed");
      else
         $display("dual_sensor_percent_seven_seg test failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("dual_sensor_percent_seven_seg test failed");
      $finish;
   end

endmodule

FILE: files.f
sv/dssp_pkg.sv
sv/dssp_if.sv
sv/dssp_front.sv
sv/dssp_queue.sv
sv/dssp_back.sv
sv/dual_sensor_percent_seven_seg.sv
verif/tb_top.sv
